// ===== rtl/jsu_pkg.sv =====
// Shared types, codes and a helper function for the JSON string unescape unit.
package jsu_pkg;

    // Parser mode codes.
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_HEX   = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EOF    = 2'd1;
    localparam logic [1:0] ST_BADESC = 2'd2;
    localparam logic [1:0] ST_BADHEX = 2'd3;

    // Characters that the parser looks for.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Control bytes produced by the letter escapes.
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    // Number of the last hex digit in a \u sequence, counted from zero.
    localparam logic [1:0] HEX_LAST = 2'd3;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        logic [1:0] parse_mode;
        logic [1:0] hex_count;
        logic [7:0] hex_accum;
    } parse_state_t;

    // One decoded result, with a flag that says whether a result exists.
    typedef struct packed {
        logic       emit;
        logic [7:0] out_byte;
        logic       string_done;
        logic [1:0] status;
    } parse_result_t;

    // Hex digit test and value; is_hex is low for a byte that is no digit.
    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.is_hex = 1'b1;
        d.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            // Letters a..f and A..F share the low three bits: 1..6 maps to 10..15.
            d.value = {1'b1, 3'(c[2:0] + 3'd1)};
        end
        else begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== rtl/json_string_unescape_unit.sv =====
// Top level of the JSON string unescape unit: input register, decode, result register.
// The unit takes one byte of a JSON string body per cycle and returns decoded bytes,
// an end-of-string marker, or an error status. Every transaction passes through an
// input register and a result register, with the decode between them. A new byte is
// accepted in every cycle as long as the result register is free or its result is
// taken in the same cycle. Backslash, the letter u and the first three hex digits of
// an escape produce no result. After a closing quote, end of input or any error the
// unit is back in plain mode and starts a new string body.
module json_string_unescape_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       at_eof,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       string_done,
    output logic [1:0] status
);
    import jsu_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          at_eof_reg;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t result_next;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          string_done_reg;
    logic [1:0]    status_reg;
    logic          advance;

    // The held byte moves on whenever the result register can take a result.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    jsu_decode u_decode (
        .cur_state  (state_reg),
        .in_byte    (in_byte_reg),
        .at_eof     (at_eof_reg),
        .next_state (state_next),
        .result     (result_next)
    );

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
            at_eof_reg  <= at_eof;
        end
    end

    // Parser state advances once per decoded byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{parse_mode: MODE_PLAIN, hex_count: 2'd0, hex_accum: 8'd0};
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= advance && result_next.emit;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance && result_next.emit)
        begin
            out_byte_reg    <= result_next.out_byte;
            string_done_reg <= result_next.string_done;
            status_reg      <= result_next.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign string_done = string_done_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    // A marker or error result never carries a data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (string_done_reg || status_reg != ST_OK) |-> out_byte_reg == 8'd0)
        else $error("marker or error result carries a nonzero byte");

    // The hex digit count is only nonzero inside a \u escape.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.parse_mode != MODE_HEX |-> state_reg.hex_count == 2'd0)
        else $error("hex digit count left over outside hex mode");

    // A decoded end-of-input always returns the parser to plain mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && at_eof_reg |=> state_reg.parse_mode == MODE_PLAIN)
        else $error("parser not in plain mode after end of input");

    // A held result is never overwritten while the output side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !advance)
        else $error("decoded byte advanced into a stalled result register");
`endif

endmodule

// ===== rtl/jsu_decode.sv =====
// Combinational next-state and result logic for one byte of a JSON string body.
module jsu_decode (
    input  jsu_pkg::parse_state_t  cur_state,
    input  logic [7:0]             in_byte,
    input  logic                   at_eof,
    output jsu_pkg::parse_state_t  next_state,
    output jsu_pkg::parse_result_t result
);
    import jsu_pkg::*;

    hex_digit_t  digit;
    logic [7:0]  shifted_accum;

    assign digit         = hex_decode(in_byte);
    assign shifted_accum = {cur_state.hex_accum[3:0], digit.value};

    // Mode update and result selection.
    always_comb
    begin
        next_state             = '{parse_mode: MODE_PLAIN, hex_count: 2'd0, hex_accum: 8'd0};
        result.emit            = 1'b0;
        result.out_byte        = 8'd0;
        result.string_done     = 1'b0;
        result.status          = ST_OK;

        if (at_eof)
        begin
            // End of input in any mode reports and drops back to plain mode.
            result.emit   = 1'b1;
            result.status = ST_EOF;
        end
        else if (cur_state.parse_mode == MODE_ESC)
        begin
            result.emit = 1'b1;
            unique case (in_byte)
                CH_B:     result.out_byte = CTL_BS;
                CH_F:     result.out_byte = CTL_FF;
                CH_N:     result.out_byte = CTL_LF;
                CH_R:     result.out_byte = CTL_CR;
                CH_T:     result.out_byte = CTL_HT;
                CH_QUOTE,
                CH_BSL,
                CH_SLASH: result.out_byte = in_byte;
                CH_U:
                begin
                    // Start of a four-digit hex escape; no result yet.
                    result.emit           = 1'b0;
                    next_state.parse_mode = MODE_HEX;
                end
                default:  result.status = ST_BADESC;
            endcase
        end
        else if (cur_state.parse_mode == MODE_HEX)
        begin
            if (!digit.is_hex)
            begin
                result.emit   = 1'b1;
                result.status = ST_BADHEX;
            end
            else if (cur_state.hex_count == HEX_LAST)
            begin
                // Last digit: the low byte of the value is the result.
                result.emit     = 1'b1;
                result.out_byte = shifted_accum;
            end
            else
            begin
                next_state.parse_mode = MODE_HEX;
                next_state.hex_count  = cur_state.hex_count + 2'd1;
                next_state.hex_accum  = shifted_accum;
            end
        end
        else
        begin
            // Plain mode; the unused mode code behaves the same way.
            if (in_byte == CH_QUOTE)
            begin
                result.emit        = 1'b1;
                result.string_done = 1'b1;
            end
            else if (in_byte == CH_BSL)
            begin
                next_state.parse_mode = MODE_ESC;
            end
            else
            begin
                result.emit     = 1'b1;
                result.out_byte = in_byte;
                next_state.hex_count = cur_state.hex_count;
                next_state.hex_accum = cur_state.hex_accum;
            end
        end
    end

endmodule
